// ===== hw/rtl/plr_pkg.sv =====
// ----------------------------------------------------------------------------
// plr_pkg: packet loss ratio meter shared definitions
// Request/result payload types, probe and cell control types, codes and
// constants used across the meter's cells, divider and top level.
// ----------------------------------------------------------------------------
package plr_pkg;

  // Default capacity of the distinct-ID set
  localparam int SET_DEPTH_DEF = 64;

  // Configuration port geometry
  localparam int PADDR_W = 3;
  localparam int PDATA_W = 32;
  localparam logic REG_MIN_SPAN = 1'b0;   // word select paddr[2]
  localparam logic [15:0] MIN_SPAN_RST = 16'd10;

  // Action codes
  localparam logic [1:0] ACT_CLEAR  = 2'd0;
  localparam logic [1:0] ACT_WIDEN  = 2'd1;
  localparam logic [1:0] ACT_INSERT = 2'd2;
  localparam logic [1:0] ACT_BOTH   = 2'd3;

  // Insert status codes
  localparam logic [1:0] STAT_INSERTED = 2'd0;
  localparam logic [1:0] STAT_DUP      = 2'd1;
  localparam logic [1:0] STAT_FULL     = 2'd2;
  localparam logic [1:0] STAT_NONE     = 2'd3;

  // Percent scale and span reset values
  localparam logic [6:0]         PCT_FULL = 7'd100;
  localparam logic signed [31:0] ID_MAX   = 32'sh7FFF_FFFF;
  localparam logic signed [31:0] ID_MIN   = 32'sh8000_0000;

  typedef struct packed {
    logic [1:0]         action;
    logic signed [31:0] packet_id;
  } in_t;

  typedef struct packed {
    logic [1:0] insert_status;
    logic [6:0] loss_percent;
  } out_t;

  // Search token that walks the row of cells
  typedef struct packed {
    logic        valid;
    logic        hit;
    logic [31:0] id;
  } probe_t;

  // Broadcast control for the cells
  typedef struct packed {
    logic clear;
    logic write;
  } cell_ctl_t;

endpackage

// ===== hw/rtl/plr_cell.sv =====
// ----------------------------------------------------------------------------
// plr_cell: one entry of the distinct-ID set
// Holds one stored ID and its valid bit, checks the passing probe against it
// and registers the probe on its way to the next cell.
// ----------------------------------------------------------------------------
module plr_cell import plr_pkg::*; #(
  parameter int IDX_W = 6,
  parameter int INDEX = 0
) (
  input  logic             clk,
  input  logic             rst,
  input  cell_ctl_t        ctl,
  input  logic [IDX_W-1:0] wr_idx,
  input  logic [31:0]      wr_id,
  input  probe_t           probe_in,
  output probe_t           probe_out
);

  logic        valid;
  logic [31:0] id;
  logic        match;

  assign match = probe_in.valid && valid && (id == probe_in.id);

  // Hold the entry; load on an addressed write, drop on clear
  always_ff @(posedge clk) begin
    if (rst || ctl.clear) begin
      valid <= 1'b0;
    end else if (ctl.write && (wr_idx == IDX_W'(INDEX))) begin
      valid <= 1'b1;
    end
    if (ctl.write && (wr_idx == IDX_W'(INDEX))) begin
      id <= wr_id;
    end
  end

  // Advance the probe, folding in this entry's match
  always_ff @(posedge clk) begin
    if (rst) begin
      probe_out.valid <= 1'b0;
    end else begin
      probe_out.valid <= probe_in.valid;
    end
    probe_out.hit <= probe_in.hit | match;
    probe_out.id  <= probe_in.id;
  end

endmodule

// ===== hw/rtl/plr_chain.sv =====
// ----------------------------------------------------------------------------
// plr_chain: row of set cells
// Links DEPTH cells head to tail; a probe entering the head passes through
// every cell's register and leaves the tail with the OR of all matches.
// ----------------------------------------------------------------------------
module plr_chain import plr_pkg::*; #(
  parameter int DEPTH = SET_DEPTH_DEF,
  parameter int IDX_W = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             rst,
  input  cell_ctl_t        ctl,
  input  logic [IDX_W-1:0] wr_idx,
  input  logic [31:0]      wr_id,
  input  probe_t           head,
  output probe_t           tail
);

  probe_t links [DEPTH+1];

  assign links[0] = head;
  assign tail     = links[DEPTH];

  // Build the row
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    plr_cell #(
      .IDX_W (IDX_W),
      .INDEX (i)
    ) u_cell (
      .clk       (clk),
      .rst       (rst),
      .ctl       (ctl),
      .wr_idx    (wr_idx),
      .wr_id     (wr_id),
      .probe_in  (links[i]),
      .probe_out (links[i+1])
    );
  end

endmodule

// ===== hw/rtl/plr_divider.sv =====
// ----------------------------------------------------------------------------
// plr_divider: serial restoring divider
// Divides an NUM_W-bit numerator by a positive 31-bit divisor, one quotient
// bit per cycle; done pulses when the quotient is ready.
// ----------------------------------------------------------------------------
module plr_divider import plr_pkg::*; #(
  parameter int NUM_W = 13
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [NUM_W-1:0] num,
  input  logic [30:0]      den,
  output logic             done,
  output logic [NUM_W-1:0] quo
);

  localparam int CNT_W = $clog2(NUM_W + 1);

  logic [CNT_W-1:0] cnt;
  logic [30:0]      rem;
  logic [30:0]      den_q;
  logic [NUM_W-1:0] shreg;
  logic [31:0]      trial;
  logic             ge;

  assign trial = {rem, shreg[NUM_W-1]};
  assign ge    = trial >= {1'b0, den_q};
  assign quo   = shreg;

  // Shift one numerator bit into the remainder and one quotient bit out
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt  <= '0;
      done <= 1'b0;
    end else if (start) begin
      cnt  <= CNT_W'(NUM_W);
      done <= 1'b0;
    end else if (cnt != '0) begin
      cnt  <= cnt - 1'b1;
      done <= (cnt == CNT_W'(1));
    end else begin
      done <= 1'b0;
    end
    if (start) begin
      rem   <= '0;
      den_q <= den;
      shreg <= num;
    end else if (cnt != '0) begin
      rem   <= ge ? 31'(trial - {1'b0, den_q}) : trial[30:0];
      shreg <= {shreg[NUM_W-2:0], ge};
    end
  end

endmodule

// ===== hw/rtl/packet_loss_ratio_meter_unit.sv =====
// ----------------------------------------------------------------------------
// packet_loss_ratio_meter_unit: packet loss ratio meter
// Tracks the span of received packet IDs and a set of distinct IDs, and
// reports the loss percent after every request.
// ----------------------------------------------------------------------------
// Usage:
//   Request channel: drive request and raise start; the request is taken at
//   an edge where start is high and busy is low. busy stays high until the
//   result is out; a clear never raises it.
//   Result channel: done pulses for one cycle with result valid; the
//   receiver cannot stall and must take it in that cycle. A new request may
//   be issued in the cycle that done is high.
//   Sequence from accept to done: a clear reports straight from idle; widen
//   only passes through prep and, when a ratio is reported, the serial
//   divide; an insert first waits in search while the probe walks the
//   SET_DEPTH cells. NUM_W = clog2(100*SET_DEPTH+1) is the serial divider
//   length, 13 at the default depth.
//   One request is in flight at a time.
//   Configuration: APB register min_span at byte address 0; the user must
//   write it only while idle, the block does not enforce it; pready is always high.
//   Reset clears span, set and count and loads min_span with 10; no
//   clearing pass is needed.
// ----------------------------------------------------------------------------
module packet_loss_ratio_meter_unit import plr_pkg::*; #(
  parameter int SET_DEPTH = SET_DEPTH_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  in_t                request,
  output logic               done,
  output out_t               result,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [PDATA_W-1:0] pwdata,
  output logic [PDATA_W-1:0] prdata,
  output logic               pready
);

  localparam int IDX_W = $clog2(SET_DEPTH);
  localparam int CNT_W = $clog2(SET_DEPTH + 1);
  localparam int NUM_W = $clog2(100 * SET_DEPTH + 1);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SEARCH,
    ST_PREP,
    ST_DIV
  } state_t;

  state_t             state;
  logic [15:0]        min_span;
  logic signed [31:0] lowest_id;
  logic signed [31:0] highest_id;
  logic               seen_any;
  logic [CNT_W-1:0]   entry_count;
  logic [1:0]         status_q;

  logic               accept;
  logic               widen;
  logic               insert;
  cell_ctl_t          ctl;
  probe_t             head;
  probe_t             tail;
  logic               set_full;

  logic [31:0]        diff_fwd;
  logic [31:0]        diff_rev;
  logic [31:0]        span;
  logic               span_ok;
  logic               div_start;
  logic               div_done;
  logic [NUM_W-1:0]   div_num;
  logic [NUM_W-1:0]   div_quo;
  logic [6:0]         loss;

  // Configuration register
  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_MIN_SPAN) ? {16'b0, min_span} : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      min_span <= MIN_SPAN_RST;
    end else if (psel && penable && pwrite && pready && (paddr[2] == REG_MIN_SPAN)) begin
      min_span <= pwdata[15:0];
    end
  end

  // Decode the request
  assign busy   = (state != ST_IDLE);
  assign accept = start && !busy;

  always_comb begin
    widen  = 1'b0;
    insert = 1'b0;
    unique case (request.action) inside
      ACT_WIDEN:            widen  = 1'b1;
      ACT_INSERT:           insert = 1'b1;
      ACT_BOTH:             begin
        widen  = 1'b1;
        insert = 1'b1;
      end
      default:              ;
    endcase
  end

  // Probe injection and set write-back
  assign set_full   = (entry_count >= CNT_W'(SET_DEPTH));
  assign head.valid = accept && insert;
  assign head.hit   = 1'b0;
  assign head.id    = request.packet_id;
  assign ctl.clear  = accept && (request.action == ACT_CLEAR);
  assign ctl.write  = (state == ST_SEARCH) && tail.valid && !tail.hit && !set_full;

  plr_chain #(
    .DEPTH (SET_DEPTH),
    .IDX_W (IDX_W)
  ) u_chain (
    .clk    (clk),
    .rst    (rst),
    .ctl    (ctl),
    .wr_idx (entry_count[IDX_W-1:0]),
    .wr_id  (tail.id),
    .head   (head),
    .tail   (tail)
  );

  // Span, mirrored when negative, and the report check
  assign diff_fwd = 32'(highest_id - lowest_id + 32'sd1);
  assign diff_rev = 32'(lowest_id - highest_id + 32'sd1);
  assign span     = diff_fwd[31] ? diff_rev : diff_fwd;
  assign span_ok  = seen_any && !span[31] && (span != '0) && (span >= {16'b0, min_span});

  // Ratio divider
  assign div_start = (state == ST_PREP) && span_ok;
  assign div_num   = NUM_W'(NUM_W'(entry_count) * NUM_W'(PCT_FULL));

  plr_divider #(
    .NUM_W (NUM_W)
  ) u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (div_num),
    .den   (span[30:0]),
    .done  (div_done),
    .quo   (div_quo)
  );

  assign loss = (div_quo >= NUM_W'(PCT_FULL)) ? 7'd0 : 7'(PCT_FULL - div_quo[6:0]);

  // Sequence the request and hold state and result registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      done        <= 1'b0;
      lowest_id   <= ID_MAX;
      highest_id  <= ID_MIN;
      seen_any    <= 1'b0;
      entry_count <= '0;
    end else begin
      done <= 1'b0;
      unique case (state)
        ST_IDLE: begin
          if (accept) begin
            if (request.action == ACT_CLEAR) begin
              lowest_id            <= ID_MAX;
              highest_id           <= ID_MIN;
              seen_any             <= 1'b0;
              entry_count          <= '0;
              done                 <= 1'b1;
              result.insert_status <= STAT_NONE;
              result.loss_percent  <= 7'd0;
            end else begin
              if (widen) begin
                if (request.packet_id < lowest_id) begin
                  lowest_id <= request.packet_id;
                end
                if (request.packet_id > highest_id) begin
                  highest_id <= request.packet_id;
                end
                seen_any <= 1'b1;
              end
              status_q <= STAT_NONE;
              state    <= insert ? ST_SEARCH : ST_PREP;
            end
          end
        end
        ST_SEARCH: begin
          if (tail.valid) begin
            if (tail.hit) begin
              status_q <= STAT_DUP;
            end else if (set_full) begin
              status_q <= STAT_FULL;
            end else begin
              status_q    <= STAT_INSERTED;
              entry_count <= entry_count + 1'b1;
            end
            state <= ST_PREP;
          end
        end
        ST_PREP: begin
          if (span_ok) begin
            state <= ST_DIV;
          end else begin
            done                 <= 1'b1;
            result.insert_status <= status_q;
            result.loss_percent  <= 7'd0;
            state                <= ST_IDLE;
          end
        end
        ST_DIV: begin
          if (div_done) begin
            done                 <= 1'b1;
            result.insert_status <= status_q;
            result.loss_percent  <= loss;
            state                <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // Checks
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    entry_count <= CNT_W'(SET_DEPTH))
    else $error("entry count beyond set depth");

  a_probe_in_search: assert property (@(posedge clk) disable iff (rst)
    tail.valid |-> (state == ST_SEARCH))
    else $error("probe left the row outside a search");

  a_div_in_div: assert property (@(posedge clk) disable iff (rst)
    div_done |-> (state == ST_DIV))
    else $error("divider finished outside the divide state");

  a_loss_range: assert property (@(posedge clk) disable iff (rst)
    done |-> (result.loss_percent <= PCT_FULL))
    else $error("loss percent above 100");

  a_busy_done: assert property (@(posedge clk) disable iff (rst)
    done && $past(state != ST_IDLE) |-> !busy)
    else $error("result issued while still busy");

endmodule
